// File: src/mcnpc_pkg.sv
`default_nettype none
package mcnpc_pkg;

    localparam int COORD_BITS            = 20;
    localparam int SUM_BITS              = COORD_BITS + 18;
    localparam int RND_BITS              = SUM_BITS + 1;
    localparam int NUM_BITS              = COORD_BITS + 16;
    localparam int RECIP_SHIFT           = NUM_BITS + 17;
    localparam int RECIP_BITS            = RECIP_SHIFT - 16;
    localparam int DIGIT_BITS            = 12;
    localparam int DIV_STEPS             = NUM_BITS / DIGIT_BITS;
    localparam int DIV_CNT_BITS          = $clog2(DIV_STEPS + 1);
    localparam int PROD_BITS             = NUM_BITS + RECIP_BITS;
    localparam int WEIGHT_BITS           = 14;
    localparam int WEIGHT_TOTAL          = 70257;
    localparam int CUTOFF_BITS           = 19;
    localparam int MCOUNT_BITS           = 9;
    localparam int COUNT_BITS            = 16;
    localparam int SLOT_BITS             = 3;
    localparam int DEFAULT_MAX_MOLECULES = 256;
    localparam logic [CUTOFF_BITS-1:0] CUTOFF_RESET = CUTOFF_BITS'(2560);
    localparam logic [MCOUNT_BITS-1:0] MCOUNT_RESET = MCOUNT_BITS'(250);
    localparam logic [SLOT_BITS-1:0]   CLOSING_SLOT = SLOT_BITS'(6);

    typedef enum logic [0:0] {
        CFG_CUTOFF         = 1'b0,
        CFG_MOLECULE_COUNT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic                         species;
        logic [SLOT_BITS-1:0]         atom_slot;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
        logic                         last_of_frame;
    } atom_word_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] surfactant_pairs;
        logic [COUNT_BITS-1:0] mimic_pairs;
    } result_word_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic store_en;
        logic cnt_clear;
        logic ld_ref;
        logic cmp_issue;
        logic fill_clear;
        logic out_load;
        logic walk_sp;
    } dp_cmd_t;

    typedef struct packed {
        logic closes;
        logic last;
        logic out_free;
    } dp_status_t;

    // Bead mass weights, unsigned Q.8
    function automatic logic [WEIGHT_BITS-1:0] bead_weight(input logic [SLOT_BITS-1:0] slot);
        logic [WEIGHT_BITS-1:0] w;
        case (slot)
            3'd0:    w = WEIGHT_BITS'(7944);
            3'd1:    w = WEIGHT_BITS'(11277);
            3'd2:    w = WEIGHT_BITS'(11277);
            3'd3:    w = WEIGHT_BITS'(10773);
            3'd4:    w = WEIGHT_BITS'(10773);
            3'd5:    w = WEIGHT_BITS'(10773);
            3'd6:    w = WEIGHT_BITS'(7440);
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// File: src/mcnpc_ram.sv
`default_nettype none
module mcnpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: src/mcnpc_datapath.sv
`default_nettype none
module mcnpc_datapath #(
    parameter int MAX_MOLECULES = mcnpc_pkg::DEFAULT_MAX_MOLECULES,
    localparam int AW = $clog2(MAX_MOLECULES),
    localparam int FW = $clog2(MAX_MOLECULES + 1),
    localparam int EW = 3 * mcnpc_pkg::COORD_BITS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire mcnpc_pkg::atom_word_t            atom,
    input  wire logic                             cfg_we,
    input  wire mcnpc_pkg::cfg_index_t            cfg_index,
    input  wire logic [mcnpc_pkg::CUTOFF_BITS-1:0] cfg_data,
    input  wire mcnpc_pkg::dp_cmd_t               cmd,
    output mcnpc_pkg::dp_status_t                 status,
    output logic      [FW-1:0]                    walk_n,
    output logic                                  surf_we,
    output logic                                  mimic_we,
    output logic      [AW-1:0]                    waddr,
    output logic      [EW-1:0]                    wdata,
    input  wire logic [EW-1:0]                    surf_rdata,
    input  wire logic [EW-1:0]                    mimic_rdata,
    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output mcnpc_pkg::result_word_t               result
);
    import mcnpc_pkg::*;

    localparam int LW = (FW > MCOUNT_BITS) ? FW : MCOUNT_BITS;
    localparam int CW = (COORD_BITS + 1 > CUTOFF_BITS) ? COORD_BITS + 1 : CUTOFF_BITS;
    localparam int PW = DIGIT_BITS + RECIP_BITS;
    localparam logic [RND_BITS-1:0]   HALF_WT = RND_BITS'(WEIGHT_TOTAL / 2);
    // largest dividend that matters: anything above saturates the same way
    localparam logic [NUM_BITS-1:0]   NUM_LIM =
        NUM_BITS'(((64'd1 << (COORD_BITS - 1)) + 64'd1) * 64'(WEIGHT_TOTAL));
    localparam logic [RECIP_BITS-1:0] RECIP =
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'(WEIGHT_TOTAL) - 64'd1) / 64'(WEIGHT_TOTAL));
    localparam logic [COORD_BITS-1:0] POS_MAX = COORD_BITS'((64'd1 << (COORD_BITS - 1)) - 64'd1);
    localparam logic [COORD_BITS-1:0] NEG_MAG = COORD_BITS'(64'd1 << (COORD_BITS - 1));

    logic [CUTOFF_BITS-1:0]  cutoff_reg;
    logic [MCOUNT_BITS-1:0]  mcount_reg;
    logic signed [SUM_BITS-1:0] acc_reg [3];
    logic [NUM_BITS-1:0]     num_reg [3];
    logic [PROD_BITS-1:0]    prod_reg [3];
    logic                    neg_reg [3];
    logic                    store_sp_reg;
    logic [FW-1:0]           fill_reg [2];
    logic [EW-1:0]           ref_reg;
    logic                    cmp_v_reg;
    logic [COUNT_BITS-1:0]   cnt_reg [2];
    logic                    out_valid_reg;
    result_word_t            out_reg;

    logic signed [COORD_BITS-1:0]            coord [3];
    logic signed [COORD_BITS+WEIGHT_BITS:0]  prod [3];
    logic signed [SUM_BITS-1:0]              acc_sum [3];
    logic [SUM_BITS-1:0]                     mag [3];
    logic [RND_BITS-1:0]                     rounded [3];
    logic [PW-1:0]                           pp [3];
    logic [COORD_BITS-1:0]                   quo [3];
    logic [COORD_BITS-1:0]                   centre [3];
    logic signed [WEIGHT_BITS:0]             weight_s;
    logic [LW-1:0]                           limit;
    logic                                    room [2];
    logic [EW-1:0]                           rd;
    logic                                    close [3];
    logic signed [CW-1:0]                    diff [3];
    logic [CW-1:0]                           adiff [3];
    logic                                    hit;

    assign coord[0] = atom.pos_x;
    assign coord[1] = atom.pos_y;
    assign coord[2] = atom.pos_z;
    assign weight_s = signed'({1'b0, bead_weight(atom.atom_slot)});
    assign rd       = cmd.walk_sp ? mimic_rdata : surf_rdata;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod[k]    = coord[k] * weight_s;
            acc_sum[k] = acc_reg[k] + SUM_BITS'(prod[k]);
            mag[k]     = acc_sum[k][SUM_BITS-1] ? SUM_BITS'(-acc_sum[k]) : SUM_BITS'(acc_sum[k]);
            rounded[k] = RND_BITS'(mag[k]) + HALF_WT;
            pp[k]      = num_reg[k][NUM_BITS-1 -: DIGIT_BITS] * RECIP;
            quo[k]     = prod_reg[k][RECIP_SHIFT +: COORD_BITS];
            // saturate the rounded quotient into the coordinate range
            if (neg_reg[k])
            begin
                if (quo[k] > NEG_MAG)
                    centre[k] = {1'b1, {(COORD_BITS-1){1'b0}}};
                else
                    centre[k] = COORD_BITS'(0) - quo[k];
            end
            else
            begin
                if (quo[k] > POS_MAX)
                    centre[k] = POS_MAX;
                else
                    centre[k] = quo[k];
            end
            diff[k]  = CW'(signed'(ref_reg[k*COORD_BITS +: COORD_BITS]))
                     - CW'(signed'(rd[k*COORD_BITS +: COORD_BITS]));
            adiff[k] = diff[k][CW-1] ? CW'(-diff[k]) : CW'(diff[k]);
            close[k] = (adiff[k] != '0) && (adiff[k] <= CW'(cutoff_reg));
        end
    end

    assign hit   = close[0] && close[1] && close[2];
    assign limit = (LW'(mcount_reg) < LW'(MAX_MOLECULES)) ? LW'(mcount_reg) : LW'(MAX_MOLECULES);
    assign room[0] = LW'(fill_reg[0]) < limit;
    assign room[1] = LW'(fill_reg[1]) < limit;

    assign status.closes   = (atom.atom_slot == CLOSING_SLOT) && room[atom.species];
    assign status.last     = atom.last_of_frame;
    assign status.out_free = !out_valid_reg || !result_stall;
    assign walk_n          = fill_reg[cmd.walk_sp];

    assign surf_we  = cmd.store_en && !store_sp_reg;
    assign mimic_we = cmd.store_en && store_sp_reg;
    assign waddr    = AW'(fill_reg[store_sp_reg]);
    assign wdata    = {centre[2], centre[1], centre[0]};

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg    <= CUTOFF_RESET;
            mcount_reg    <= MCOUNT_RESET;
            acc_reg[0]    <= '0;
            acc_reg[1]    <= '0;
            acc_reg[2]    <= '0;
            fill_reg[0]   <= '0;
            fill_reg[1]   <= '0;
            cnt_reg[0]    <= '0;
            cnt_reg[1]    <= '0;
            cmp_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CUTOFF:         cutoff_reg <= cfg_data;
                    CFG_MOLECULE_COUNT: mcount_reg <= cfg_data[MCOUNT_BITS-1:0];
                    default:            cutoff_reg <= cutoff_reg;
                endcase
            end

            if (cmd.accept)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (atom.atom_slot == CLOSING_SLOT || atom.last_of_frame)
                        acc_reg[k] <= '0;
                    else
                        acc_reg[k] <= acc_sum[k];
                end
            end

            if (cmd.fill_clear)
            begin
                fill_reg[0] <= '0;
                fill_reg[1] <= '0;
            end
            else if (cmd.store_en)
            begin
                fill_reg[store_sp_reg] <= fill_reg[store_sp_reg] + FW'(1);
            end

            cmp_v_reg <= cmd.cmp_issue;
            if (cmd.cnt_clear)
            begin
                cnt_reg[0] <= '0;
                cnt_reg[1] <= '0;
            end
            else if (cmp_v_reg && hit && cnt_reg[cmd.walk_sp] != '1)
            begin
                cnt_reg[cmd.walk_sp] <= cnt_reg[cmd.walk_sp] + COUNT_BITS'(1);
            end

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            store_sp_reg <= atom.species;
            for (int k = 0; k < 3; k++)
            begin
                num_reg[k]  <= (rounded[k] > RND_BITS'(NUM_LIM)) ? NUM_LIM
                                                                  : NUM_BITS'(rounded[k]);
                prod_reg[k] <= '0;
                neg_reg[k]  <= acc_sum[k][SUM_BITS-1];
            end
        end
        else if (cmd.div_step)
        begin
            // multiply by the reciprocal one digit at a time, top digit first
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[k] <= {prod_reg[k][PROD_BITS-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}}
                             + PROD_BITS'(pp[k]);
                num_reg[k]  <= {num_reg[k][NUM_BITS-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
            end
        end
        if (cmd.ld_ref)
            ref_reg <= rd;
        if (cmd.out_load)
        begin
            out_reg.surfactant_pairs <= cnt_reg[0];
            out_reg.mimic_pairs      <= cnt_reg[1];
        end
    end

endmodule
`default_nettype wire

// File: src/mcnpc_ctrl.sv
`default_nettype none
module mcnpc_ctrl #(
    parameter int MAX_MOLECULES = mcnpc_pkg::DEFAULT_MAX_MOLECULES,
    localparam int AW = $clog2(MAX_MOLECULES),
    localparam int FW = $clog2(MAX_MOLECULES + 1)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  atom_valid,
    output logic                       atom_stall,
    input  wire mcnpc_pkg::dp_status_t status,
    input  wire logic [FW-1:0]         walk_n,
    output mcnpc_pkg::dp_cmd_t         cmd,
    output logic      [AW-1:0]         raddr
);
    import mcnpc_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DIV    = 9'b000000010,
        S_STORE  = 9'b000000100,
        S_PICK   = 9'b000001000,
        S_LOAD_I = 9'b000010000,
        S_HOLD_I = 9'b000100000,
        S_SCAN   = 9'b001000000,
        S_DRAIN  = 9'b010000000,
        S_EMIT   = 9'b100000000
    } state_t;

    state_t                  state_reg, state_next;
    logic                    last_reg, last_next;
    logic [DIV_CNT_BITS-1:0] div_cnt_reg, div_cnt_next;
    logic                    sp_reg, sp_next;
    logic [AW-1:0]           i_reg, i_next;
    logic [AW-1:0]           j_reg, j_next;
    logic [AW-1:0]           n_m1;
    logic                    accept;

    assign accept     = atom_valid && (state_reg == S_IDLE);
    assign atom_stall = (state_reg != S_IDLE);
    assign n_m1       = AW'(walk_n - FW'(1));
    assign raddr      = (state_reg == S_LOAD_I) ? i_reg : j_reg;

    always_comb
    begin
        state_next   = state_reg;
        last_next    = last_reg;
        div_cnt_next = div_cnt_reg;
        sp_next      = sp_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        cmd          = '0;
        cmd.accept   = accept;
        cmd.walk_sp  = sp_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    last_next     = status.last;
                    cmd.cnt_clear = status.last;
                    sp_next       = 1'b0;
                    if (status.closes)
                    begin
                        div_cnt_next = '0;
                        state_next   = S_DIV;
                    end
                    else if (status.last)
                    begin
                        state_next = S_PICK;
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + DIV_CNT_BITS'(1);
                if (div_cnt_reg == DIV_CNT_BITS'(DIV_STEPS - 1))
                    state_next = S_STORE;
            end
            S_STORE:
            begin
                cmd.store_en = 1'b1;
                state_next   = last_reg ? S_PICK : S_IDLE;
            end
            S_PICK:
            begin
                // skip a species with an empty table
                if (walk_n == '0)
                begin
                    if (sp_reg)
                        state_next = S_EMIT;
                    else
                        sp_next = 1'b1;
                end
                else
                begin
                    i_next     = '0;
                    state_next = S_LOAD_I;
                end
            end
            S_LOAD_I:
            begin
                state_next = S_HOLD_I;
            end
            S_HOLD_I:
            begin
                cmd.ld_ref = 1'b1;
                j_next     = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.cmp_issue = 1'b1;
                j_next        = j_reg + AW'(1);
                if (j_reg == n_m1)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (i_reg == n_m1)
                begin
                    if (sp_reg)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        sp_next    = 1'b1;
                        state_next = S_PICK;
                    end
                end
                else
                begin
                    i_next     = i_reg + AW'(1);
                    state_next = S_LOAD_I;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.fill_clear = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            last_reg    <= 1'b0;
            div_cnt_reg <= '0;
            sp_reg      <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            last_reg    <= last_next;
            div_cnt_reg <= div_cnt_next;
            sp_reg      <= sp_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
        end
    end

endmodule
`default_nettype wire

// File: src/molecule_com_neighbor_pair_counter.sv
// Same-species neighbor pair counter over molecule centers of mass.
// Atom channel (atom_valid / atom_stall / atom): one atom word per accept.
// Each word is weighted by its bead slot and summed; slot 6 closes a
// molecule, whose center is divided out and stored in its species table if it has room.
// Result channel (result_valid / result_stall / result): one word per frame,
// the ordered pair counts for both species.
// Steps: an ordinary atom needs only its accept. A closing atom passes
// through the accept, three multiply steps by the reciprocal of the weight
// total (one 12-bit digit of the dividend each) and the table write.
// On last_of_frame the pair walk reads the species tables through a shared
// read address, one row per cycle while it scans: each stored center in
// turn is compared with every row of its table, an empty table is skipped,
// then the result is loaded. atom_stall is high for the whole of that work.
// If the receiver stalls, the result word holds in its output register;
// new atoms are still taken, and the next frame waits only at its end.
// Reset clears accumulators, fill counts, result valid and restores the
// cutoff and molecule count registers; the tables need no clearing.
// Configuration: cfg_we, cfg_index, cfg_data, written only while idle by the user; not enforced.
`default_nettype none
module molecule_com_neighbor_pair_counter #(
    parameter int MAX_MOLECULES = mcnpc_pkg::DEFAULT_MAX_MOLECULES
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              atom_valid,
    output logic                                   atom_stall,
    input  wire mcnpc_pkg::atom_word_t             atom,
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output mcnpc_pkg::result_word_t                result,
    input  wire logic                              cfg_we,
    input  wire mcnpc_pkg::cfg_index_t             cfg_index,
    input  wire logic [mcnpc_pkg::CUTOFF_BITS-1:0] cfg_data
);
    import mcnpc_pkg::*;

    localparam int AW = $clog2(MAX_MOLECULES);
    localparam int FW = $clog2(MAX_MOLECULES + 1);
    localparam int EW = 3 * COORD_BITS;

    dp_cmd_t     cmd;
    dp_status_t  status;
    logic [FW-1:0] walk_n;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic [EW-1:0] wdata;
    logic [EW-1:0] surf_rdata;
    logic [EW-1:0] mimic_rdata;
    logic          surf_we;
    logic          mimic_we;

    mcnpc_ctrl #(.MAX_MOLECULES(MAX_MOLECULES)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .atom_valid (atom_valid),
        .atom_stall (atom_stall),
        .status     (status),
        .walk_n     (walk_n),
        .cmd        (cmd),
        .raddr      (raddr)
    );

    mcnpc_datapath #(.MAX_MOLECULES(MAX_MOLECULES)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .atom         (atom),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .walk_n       (walk_n),
        .surf_we      (surf_we),
        .mimic_we     (mimic_we),
        .waddr        (waddr),
        .wdata        (wdata),
        .surf_rdata   (surf_rdata),
        .mimic_rdata  (mimic_rdata),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    mcnpc_ram #(.WIDTH(EW), .DEPTH(MAX_MOLECULES)) u_surf_ram (
        .clk   (clk),
        .we    (surf_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (surf_rdata)
    );

    mcnpc_ram #(.WIDTH(EW), .DEPTH(MAX_MOLECULES)) u_mimic_ram (
        .clk   (clk),
        .we    (mimic_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (mimic_rdata)
    );

endmodule
`default_nettype wire

// File: src/mcnpc_checker.sv
`default_nettype none
module mcnpc_checker (
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    atom_valid,
    input wire logic                    atom_stall,
    input wire mcnpc_pkg::atom_word_t   atom,
    input wire logic                    result_valid,
    input wire logic                    result_stall,
    input wire mcnpc_pkg::result_word_t result
);
    import mcnpc_pkg::*;

    // a stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // frame end always starts the pair walk
    a_walk_starts: assert property (@(posedge clk) disable iff (!rst_n)
        atom_valid && !atom_stall && atom.last_of_frame |=> atom_stall)
        else $error("no stall after frame end");

    // a plain atom does not stall the input in the next cycle
    a_plain_atom: assert property (@(posedge clk) disable iff (!rst_n)
        atom_valid && !atom_stall && !atom.last_of_frame
            && atom.atom_slot != CLOSING_SLOT |=> !atom_stall)
        else $error("plain atom stalled the input");

    // a result appears only at the end of a walk
    a_result_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(atom_stall))
        else $error("result without pair walk");

endmodule

bind molecule_com_neighbor_pair_counter mcnpc_checker u_mcnpc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .atom_valid   (atom_valid),
    .atom_stall   (atom_stall),
    .atom         (atom),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
`default_nettype wire
